@@ sv/png_stored_deflate_encoder_defines.svh @@
// Assertion macros used by the encoder back end
`ifndef PNG_STORED_DEFLATE_ENCODER_DEFINES_SVH
`define PNG_STORED_DEFLATE_ENCODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PSDE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PSDE_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define PSDE_ASSERT(lbl, clk, rst, prop, msg)
`define PSDE_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

@@ sv/psde_pkg.sv @@
// Shared types, constants and functions of the PNG stored-deflate encoder
`default_nettype none
package psde_pkg;
   localparam int CFG_W       = 13;
   localparam int COL_W       = 12;
   localparam int RGB_W       = 24;
   localparam int DEF_MAX_DIM = 4096;
   localparam int DEF_BLOCK   = 65535;
   localparam int Q_DEPTH     = 2;
   localparam logic [31:0] CRC_POLY  = 32'hedb88320;
   localparam logic [31:0] CRC_INIT  = 32'hffffffff;
   localparam logic [31:0] IEND_CRC  = 32'hae426082;
   localparam logic [16:0] ADLER_MOD = 17'd65521;
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;
   localparam logic [2:0] REG_WIDTH_ADDR  = 3'd0;
   localparam logic [2:0] REG_HEIGHT_ADDR = 3'd4;

   typedef struct packed {
      logic             is_start;
      logic             filter;
      logic [RGB_W-1:0] rgb;
   } op_type;

   function automatic logic [31:0] crc8(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] x;
      x = c ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         x = (x >> 1) ^ (x[0] ? CRC_POLY : 32'h0);
      end
      return x;
   endfunction

   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] maxd);
      logic [CFG_W-1:0] r;
      r = v;
      if (v == '0) r = CFG_W'(1);
      else if (v > maxd) r = maxd;
      return r;
   endfunction
endpackage
`default_nettype wire

@@ sv/psde_front.sv @@
// Front end: accepts items, tracks columns and queues start and pixel operations
`default_nettype none
module psde_front #(
   parameter int MAX_DIM = psde_pkg::DEF_MAX_DIM
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire                        req_type,
   input  wire [psde_pkg::RGB_W-1:0]  req_pixel_rgb,
   input  wire [psde_pkg::CFG_W-1:0]  image_width,
   input  wire                        q_full,
   output logic                       q_push,
   output psde_pkg::op_type           q_data
);
   import psde_pkg::*;

   logic             opened_ff, opened_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] col_inc;
   logic [CFG_W-1:0] w_c;
   logic             accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign w_c       = clamp_dim(image_width, CFG_W'(MAX_DIM));
   assign col_inc   = col_ff + COL_W'(1);

   always_comb begin
      opened_in       = opened_ff;
      col_in          = col_ff;
      q_push          = 1'b0;
      q_data.is_start = (req_type == REQ_START);
      q_data.filter   = (col_ff == '0);
      q_data.rgb      = req_pixel_rgb;
      if (accept) begin
         if (req_type == REQ_START) begin
            q_push    = 1'b1;
            opened_in = 1'b1;
            col_in    = '0;
         end else if (opened_ff) begin
            q_push = 1'b1;
            if (col_inc == '0 || {1'b0, col_inc} >= w_c) col_in = '0;
            else col_in = col_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opened_ff <= 1'b0;
         col_ff    <= '0;
      end else begin
         opened_ff <= opened_in;
         col_ff    <= col_in;
      end
   end
endmodule
`default_nettype wire

@@ sv/psde_queue.sv @@
// Two-entry operation queue between front and back
`default_nettype none
module psde_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  psde_pkg::op_type  push_data,
   input  wire               pop,
   output logic              q_valid,
   output logic              q_full,
   output psde_pkg::op_type  q_head
);
   import psde_pkg::*;

   localparam int PTR_W = $clog2(Q_DEPTH);
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   op_type             slot_ff [Q_DEPTH];
   logic [PTR_W-1:0]   wp_ff, rp_ff;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_pop;

   assign q_valid = (cnt_ff != '0);
   assign q_full  = (cnt_ff == CNT_W'(Q_DEPTH));
   assign q_head  = slot_ff[rp_ff];
   assign do_pop  = pop && q_valid;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !do_pop) cnt_in = cnt_ff + CNT_W'(1);
      else if (!push && do_pop) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= push_data;
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wp_ff + PTR_W'(1);
         if (do_pop) rp_ff <= (rp_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rp_ff + PTR_W'(1);
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

@@ sv/psde_back.sv @@
// Back end: byte sequencer, stored-block framing, checksums and output register
`default_nettype none
`include "png_stored_deflate_encoder_defines.svh"
module psde_back #(
   parameter int MAX_DIM     = psde_pkg::DEF_MAX_DIM,
   parameter int BLOCK_BYTES = psde_pkg::DEF_BLOCK
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire [psde_pkg::CFG_W-1:0]  image_width,
   input  wire [psde_pkg::CFG_W-1:0]  image_height,
   input  wire                        q_valid,
   input  psde_pkg::op_type           q_head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last_byte
);
   import psde_pkg::*;

   localparam longint RAW_MAX = (3 * longint'(MAX_DIM) + 1) * longint'(MAX_DIM);
   localparam int RAW_W = $clog2(RAW_MAX + 1);
   localparam int NUM_W = $clog2(RAW_MAX + longint'(BLOCK_BYTES));
   localparam int BLK_W = $clog2(BLOCK_BYTES + 1);
   localparam int BLK_L  = $clog2(BLOCK_BYTES);
   localparam int RCP_SH = NUM_W + BLK_L;
   localparam int RCP_W  = NUM_W + 2;
   localparam int PRD_W  = NUM_W + RCP_W;
   localparam logic [RCP_W-1:0] BLK_RCP =
      RCP_W'(((longint'(1) << RCP_SH) + longint'(BLOCK_BYTES) - 1) / longint'(BLOCK_BYTES));

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_RAW   = 3'd2;
   localparam logic [2:0] ST_BHDR  = 3'd3;
   localparam logic [2:0] ST_TRAIL = 3'd4;

   localparam logic [5:0] POS_HCRC_FIRST = 6'd12;
   localparam logic [5:0] POS_HCRC_LAST  = 6'd28;
   localparam logic [5:0] POS_IDAT_TYPE  = 6'd37;
   localparam logic [5:0] POS_START_END  = 6'd42;
   localparam logic [5:0] POS_BHDR_END   = 6'd4;
   localparam logic [5:0] POS_TR_CRC     = 6'd4;
   localparam logic [5:0] POS_TR_END     = 6'd19;
   localparam logic [1:0] SLOT_BLUE      = 2'd3;

   logic [2:0]        state_ff, state_in;
   logic [5:0]        idx_ff, idx_in;
   logic [1:0]        slot_ff, slot_in;
   logic              hdr_done_ff, hdr_done_in;
   logic              active_ff, active_in;
   logic [RAW_W-1:0]  rem_ff, rem_in;
   logic [BLK_W-1:0]  fill_ff, fill_in;
   logic [31:0]       crc_ff, crc_in;
   logic [31:0]       hcrc_ff, hcrc_in;
   logic [15:0]       alo_ff, alo_in, ahi_ff, ahi_in;
   logic [RAW_W-1:0]  raw_ff, raw_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [NUM_W-1:0]  blk_ff, blk_in;
   logic [RGB_W-1:0]  pix_ff, pix_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              can_emit, emit, emit_last, done;
   logic [7:0]        emit_byte;
   logic [CFG_W-1:0]  w_c, h_c;
   logic [CFG_W+1:0]  w3;
   logic [2*CFG_W+1:0] prod;
   logic [31:0]       idat_len;
   logic [PRD_W-1:0]  blk_prod;
   logic [15:0]       blen;
   logic              bfinal;
   logic [7:0]        raw_b;
   logic [16:0]       lo_s, hi_s;
   logic [16:0]       lo_n, hi_n;
   logic [BLK_W:0]    fill_inc;

   assign w_c  = clamp_dim(image_width, CFG_W'(MAX_DIM));
   assign h_c  = clamp_dim(image_height, CFG_W'(MAX_DIM));
   assign w3   = {1'b0, w_c, 1'b0} + {2'b0, w_c} + (CFG_W+2)'(1);
   assign prod = w3 * h_c;
   // block count: ceil(raw / BLOCK_BYTES) by reciprocal multiplication,
   // registered in num_ff and then blk_ff after the start operation is taken
   assign blk_prod = PRD_W'(num_ff) * PRD_W'(BLK_RCP);
   assign blk_in   = NUM_W'(blk_prod >> RCP_SH);
   assign idat_len = 32'(raw_ff) + 32'({blk_ff, 2'b00}) + 32'(blk_ff) + 32'd6;
   assign blen   = (rem_ff > RAW_W'(BLOCK_BYTES)) ? 16'(BLOCK_BYTES) : 16'(rem_ff);
   assign bfinal = (rem_ff <= RAW_W'(BLOCK_BYTES));
   assign can_emit = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (slot_ff)
         2'd0:    raw_b = 8'h00;
         2'd1:    raw_b = pix_ff[23:16];
         2'd2:    raw_b = pix_ff[15:8];
         default: raw_b = pix_ff[7:0];
      endcase
   end

   function automatic logic [7:0] start_byte(input logic [5:0] i, input logic [15:0] w,
                                             input logic [15:0] h, input logic [31:0] hc,
                                             input logic [31:0] il);
      logic [7:0] b;
      case (i)
         6'd0: b = 8'd137;  6'd1: b = 8'd80;  6'd2: b = 8'd78;  6'd3: b = 8'd71;
         6'd4: b = 8'd13;   6'd5: b = 8'd10;  6'd6: b = 8'd26;  6'd7: b = 8'd10;
         6'd11: b = 8'd13;
         6'd12: b = "I";    6'd13: b = "H";   6'd14: b = "D";   6'd15: b = "R";
         6'd18: b = w[15:8]; 6'd19: b = w[7:0];
         6'd22: b = h[15:8]; 6'd23: b = h[7:0];
         6'd24: b = 8'd8;   6'd25: b = 8'd2;
         6'd29: b = ~hc[31:24]; 6'd30: b = ~hc[23:16];
         6'd31: b = ~hc[15:8];  6'd32: b = ~hc[7:0];
         6'd33: b = il[31:24];  6'd34: b = il[23:16];
         6'd35: b = il[15:8];   6'd36: b = il[7:0];
         6'd37: b = "I";    6'd38: b = "D";   6'd39: b = "A";   6'd40: b = "T";
         6'd41: b = 8'h78;  6'd42: b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] trail_byte(input logic [5:0] i, input logic [31:0] ad,
                                             input logic [31:0] c);
      logic [7:0] b;
      case (i)
         6'd0: b = ad[31:24];  6'd1: b = ad[23:16];  6'd2: b = ad[15:8];  6'd3: b = ad[7:0];
         6'd4: b = ~c[31:24];  6'd5: b = ~c[23:16];  6'd6: b = ~c[15:8];  6'd7: b = ~c[7:0];
         6'd12: b = "I";  6'd13: b = "E";  6'd14: b = "N";  6'd15: b = "D";
         6'd16: b = IEND_CRC[31:24];  6'd17: b = IEND_CRC[23:16];
         6'd18: b = IEND_CRC[15:8];   6'd19: b = IEND_CRC[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      slot_in     = slot_ff;
      hdr_done_in = hdr_done_ff;
      active_in   = active_ff;
      rem_in      = rem_ff;
      fill_in     = fill_ff;
      crc_in      = crc_ff;
      hcrc_in     = hcrc_ff;
      alo_in      = alo_ff;
      ahi_in      = ahi_ff;
      raw_in      = raw_ff;
      num_in      = num_ff;
      pix_in      = pix_ff;
      emit        = 1'b0;
      emit_last   = 1'b0;
      emit_byte   = 8'h00;
      done        = 1'b0;
      lo_s = 17'({1'b0, alo_ff}) + 17'(raw_b);
      lo_n = (lo_s >= ADLER_MOD) ? lo_s - ADLER_MOD : lo_s;
      hi_s = 17'({1'b0, ahi_ff}) + lo_n;
      hi_n = (hi_s >= ADLER_MOD) ? hi_s - ADLER_MOD : hi_s;
      fill_inc = {1'b0, fill_ff} + (BLK_W+1)'(1);

      unique case (state_ff)
         ST_START: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_byte = start_byte(idx_ff, 16'(w_c), 16'(h_c), hcrc_ff, idat_len);
               if (idx_ff >= POS_HCRC_FIRST && idx_ff <= POS_HCRC_LAST)
                  hcrc_in = crc8((idx_ff == POS_HCRC_FIRST) ? CRC_INIT : hcrc_ff, emit_byte);
               if (idx_ff >= POS_IDAT_TYPE) crc_in = crc8(crc_ff, emit_byte);
               if (idx_ff == POS_START_END) begin
                  rem_in    = raw_ff;
                  active_in = 1'b1;
                  done      = 1'b1;
               end else begin
                  idx_in = idx_ff + 6'd1;
               end
            end
         end
         ST_RAW: begin
            if (!active_ff || rem_ff == '0) begin
               done = 1'b1;
            end else if (fill_ff == '0 && !hdr_done_ff) begin
               state_in = ST_BHDR;
               idx_in   = '0;
            end else if (can_emit) begin
               emit        = 1'b1;
               emit_byte   = raw_b;
               crc_in      = crc8(crc_ff, raw_b);
               alo_in      = lo_n[15:0];
               ahi_in      = hi_n[15:0];
               hdr_done_in = 1'b0;
               fill_in     = (fill_inc >= (BLK_W+1)'(BLOCK_BYTES)) ? '0 : BLK_W'(fill_inc);
               rem_in      = rem_ff - RAW_W'(1);
               if (rem_ff == RAW_W'(1)) begin
                  state_in  = ST_TRAIL;
                  idx_in    = '0;
                  active_in = 1'b0;
               end else if (slot_ff == SLOT_BLUE) begin
                  done = 1'b1;
               end else begin
                  slot_in = slot_ff + 2'd1;
               end
            end
         end
         ST_BHDR: begin
            if (can_emit) begin
               emit = 1'b1;
               case (idx_ff)
                  6'd0:    emit_byte = {7'd0, bfinal};
                  6'd1:    emit_byte = blen[7:0];
                  6'd2:    emit_byte = blen[15:8];
                  6'd3:    emit_byte = ~blen[7:0];
                  default: emit_byte = ~blen[15:8];
               endcase
               crc_in = crc8(crc_ff, emit_byte);
               if (idx_ff == POS_BHDR_END) begin
                  state_in    = ST_RAW;
                  hdr_done_in = 1'b1;
               end else begin
                  idx_in = idx_ff + 6'd1;
               end
            end
         end
         ST_TRAIL: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_byte = trail_byte(idx_ff, {ahi_ff, alo_ff}, crc_ff);
               if (idx_ff < POS_TR_CRC) crc_in = crc8(crc_ff, emit_byte);
               if (idx_ff == POS_TR_END) begin
                  emit_last = 1'b1;
                  done      = 1'b1;
               end else begin
                  idx_in = idx_ff + 6'd1;
               end
            end
         end
         default: ;
      endcase

      if (done) state_in = ST_IDLE;
      q_pop = q_valid && (state_ff == ST_IDLE || done);
      if (q_pop) begin
         if (q_head.is_start) begin
            state_in  = ST_START;
            idx_in    = '0;
            active_in = 1'b0;
            rem_in    = '0;
            fill_in   = '0;
            crc_in    = CRC_INIT;
            alo_in    = 16'd1;
            ahi_in    = 16'd0;
            raw_in    = RAW_W'(prod);
            num_in    = NUM_W'(prod) + NUM_W'(BLOCK_BYTES - 1);
         end else begin
            state_in    = ST_RAW;
            slot_in     = q_head.filter ? 2'd0 : 2'd1;
            hdr_done_in = 1'b0;
            pix_in      = q_head.rgb;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_last_in  = emit_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      slot_ff     <= slot_in;
      hcrc_ff     <= hcrc_in;
      raw_ff      <= raw_in;
      num_ff      <= num_in;
      blk_ff      <= blk_in;
      pix_ff      <= pix_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         hdr_done_ff  <= 1'b0;
         active_ff    <= 1'b0;
         rem_ff       <= '0;
         fill_ff      <= '0;
         crc_ff       <= CRC_INIT;
         alo_ff       <= 16'd1;
         ahi_ff       <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hdr_done_ff  <= hdr_done_in;
         active_ff    <= active_in;
         rem_ff       <= rem_in;
         fill_ff      <= fill_in;
         crc_ff       <= crc_in;
         alo_ff       <= alo_in;
         ahi_ff       <= ahi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_last_byte = rsp_last_ff;

   `PSDE_ASSERT_NEXT(a_rsp_hold, clock, reset, (rsp_valid_ff && rsp_stall), (rsp_valid_ff && $stable(rsp_byte_ff) && $stable(rsp_last_ff)), "stalled byte changed")
   `PSDE_ASSERT_NEXT(a_last_closes, clock, reset, (emit && emit_last), (!active_ff), "image still open after last byte")
   `PSDE_ASSERT(a_fill_range, clock, reset, (fill_ff < BLK_W'(BLOCK_BYTES)), "block fill out of range")
   `PSDE_ASSERT(a_data_active, clock, reset, (state_ff == ST_RAW && emit) |-> (active_ff && rem_ff != '0), "raw byte sent with no image open")
endmodule
`default_nettype wire

@@ sv/png_stored_deflate_encoder.sv @@
// Top level of the PNG stored-deflate encoder for 8-bit RGB rasters
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_type, req_pixel_rgb
//   rsp      out        rsp_valid/rsp_stall  rsp_out_byte, rsp_last_byte
//   csr      in/out     psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// At most one byte leaves per cycle, none while rsp is stalled. A pixel sends 3
// bytes (4 when it opens a row), and a stored block that opens costs one
// framing step plus the 5 header bytes. A start item sends 43 bytes; the block
// count for the IDAT length is registered in num_ff and then blk_ff after the
// start item is taken. Reset is synchronous and clears the control state except
// the back end's byte index and pixel slot registers.
// A two-entry queue parts the front from the back, so req keeps flowing while
// rsp is stalled until the queue fills.
`default_nettype none
module png_stored_deflate_encoder #(
   parameter int MAX_DIM     = psde_pkg::DEF_MAX_DIM,
   parameter int BLOCK_BYTES = psde_pkg::DEF_BLOCK
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire                        req_type,
   input  wire [psde_pkg::RGB_W-1:0]  req_pixel_rgb,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last_byte,
   input  wire                        psel,
   input  wire                        penable,
   input  wire                        pwrite,
   input  wire [2:0]                  paddr,
   input  wire [31:0]                 pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import psde_pkg::*;

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic             cfg_wr;
   logic             q_push, q_pop, q_valid, q_full;
   op_type           q_data, q_head;

   // register file: index by word address, byte offset ignored
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (cfg_wr) begin
         if (paddr[2] == REG_HEIGHT_ADDR[2]) height_in = pwdata[CFG_W-1:0];
         else width_in = pwdata[CFG_W-1:0];
      end
      if (paddr[2] == REG_HEIGHT_ADDR[2]) prdata = 32'(height_ff);
      else prdata = 32'(width_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(1);
         height_ff <= CFG_W'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // front: classify items, drop pixels before the first start
   psde_front #(.MAX_DIM(MAX_DIM)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_pixel_rgb (req_pixel_rgb),
      .image_width   (width_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_data)
   );

   // hold pending operations between front and back
   psde_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .q_full    (q_full),
      .q_head    (q_head)
   );

   // back: advance at most one stream byte a cycle into the output register, none while a held byte is stalled
   psde_back #(.MAX_DIM(MAX_DIM), .BLOCK_BYTES(BLOCK_BYTES)) u_back (
      .clock         (clock),
      .reset         (reset),
      .image_width   (width_ff),
      .image_height  (height_ff),
      .q_valid       (q_valid),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );
endmodule
`default_nettype wire
